[rtl/fixed_block_free_list_allocator_macros.svh]
// Assertion macros for the fixed block free-list allocator.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define FBFL_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define FBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FBFL_ASSERT(label, clk, rst_n, ante, cons, msg)
`define FBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/fbfl_pkg.sv]
// Package for the fixed block free-list allocator: field widths, codes and FSM states.
// No dependencies.
package fbfl_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 4096;
  localparam int unsigned ADDR_BITS_DEF  = 48;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned INDEX_W    = 12;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [SIZE_W-1:0] MIN_BLOCK_SIZE = 16'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC,
    ACT_FREE,
    ACT_IDX2ADDR,
    ACT_ADDR2IDX
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_EXHAUSTED,
    STAT_RANGE,
    STAT_NULL
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK,
    ST_DIV,
    ST_CHECK,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

endpackage

[rtl/fbfl_if.sv]
// Valid/ready channel interfaces of the allocator: request, result and register write.
// Depends on fbfl_pkg.
interface fbfl_in_if;
  import fbfl_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   address;
  logic [INDEX_W-1:0]  block_index;
  logic                is_null;
  modport source (output valid, action, address, block_index, is_null, input ready);
  modport sink   (input valid, action, address, block_index, is_null, output ready);
endinterface

interface fbfl_out_if;
  import fbfl_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   result_address;
  logic [INDEX_W-1:0]  result_index;
  modport source (output valid, status, result_address, result_index, input ready);
  modport sink   (input valid, status, result_address, result_index, output ready);
endinterface

interface fbfl_cfg_if;
  import fbfl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

[rtl/fixed_block_free_list_allocator.sv]
// Fixed-size block pool allocator with a linked free list held in a link RAM.
// Depends on fbfl_pkg, the channel interfaces in fbfl_if.sv and the assertion macros.
//
// Usage:
//   cfg_i  : register writes (0 base address, 1 block size, 2 block count). Always ready.
//            Any write to a listed register empties the pool. Write only while idle.
//   in_i   : one request beat per item: allocate, free address, index to address,
//            address to index. Ready only while no item is in flight.
//   out_o  : one result beat per request: status, address, index.
// Steps from request beat to the output register:
//   allocate from the free list  link RAM read, multiply, add
//   allocate a fresh index       multiply, add; pool exhausted, null or index miss go straight to the result
//   index to address             multiply, add
//   free / address to index      restoring division retiring one quotient bit per cycle over
//                                CW = clog2(MAX_BLOCKS + 1) bits (13 bits at 4096 blocks), then
//                                the range check; address to index then multiplies and adds
// One item is in flight at a time; the next request is taken as soon as the result sits
// in the output register, even if the receiver has not taken it yet.
// Reset: pool empty, base 0, block size 4, block count 0. The link RAM is not cleared;
// only entries written by a free are ever read back.
// Receiver stall: the result is held in the output register; a following item runs up to
// its result stage and waits there until the register drains.
`include "fixed_block_free_list_allocator_macros.svh"

module fixed_block_free_list_allocator #(
  parameter int unsigned MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_BITS  = fbfl_pkg::ADDR_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbfl_cfg_if.sink   cfg_i,
  fbfl_in_if.sink    in_i,
  fbfl_out_if.source out_o
);
  import fbfl_pkg::*;

  // effective address width, index width, count/link width (index + 1 fits)
  localparam int unsigned AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  // remainder, divisor and product width
  localparam int unsigned RW = SIZE_W + CW;
  localparam int unsigned KW = $clog2(CW + 1);
  // width for the quotient overflow check
  localparam int unsigned XW = AW + RW;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [AW-1:0]     base_q, base_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     head_q, head_d;    // free list head, index + 1, zero when empty
  logic [CW-1:0]     hw_q, hw_d;        // high-water mark

  action_e           act_q, act_d;
  status_e           status_q, status_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     quo_q, quo_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [RW-1:0]     dvs_q, dvs_d;
  logic [KW-1:0]     cnt_q, cnt_d;
  logic [RW-1:0]     prod_q, prod_d;
  logic [AW-1:0]     addr_q, addr_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [INDEX_W-1:0]  out_idx_q;

  // link RAM: successor of each freed block, stored as index + 1
  logic [CW-1:0] link_mem [MAX_BLOCKS];
  logic [CW-1:0] link_rdata_q;
  logic          mem_re;
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [CW-1:0] mem_wdata;

  // ---------------------------------------------------------------------------
  // Handshakes and request decode
  // ---------------------------------------------------------------------------
  logic          in_fire;
  logic          cfg_fire;
  logic          cfg_hit;
  logic          out_load;
  action_e       in_act;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] diff;
  logic          addr_low;
  logic          quo_over;
  logic          bidx_ok;
  logic          head_nz;
  logic          hw_avail;
  logic          div_bit;
  logic [SIZE_W-1:0]  cfg_size;
  logic [COUNT_W-1:0] cfg_count;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid & in_i.ready;
  assign cfg_fire    = cfg_i.valid & cfg_i.ready;
  assign out_load    = (state_q == ST_DONE) & (~out_valid_q | out_o.ready);

  assign in_act   = action_e'(in_i.action);
  assign in_addr  = in_i.address[AW-1:0];
  assign diff     = in_addr - base_q;
  assign addr_low = (in_addr < base_q);
  // quotient would not fit in CW bits, so it is beyond any high-water mark
  assign quo_over = (XW'(diff) >= (XW'(size_q) << CW));
  assign bidx_ok  = (32'(in_i.block_index) < 32'(hw_q));
  assign head_nz  = (head_q != '0);
  assign hw_avail = (hw_q < count_q);
  assign div_bit  = (rem_q >= dvs_q);

  assign cfg_size  = cfg_i.data[SIZE_W-1:0];
  assign cfg_count = cfg_i.data[COUNT_W-1:0];
  assign cfg_hit   = cfg_fire & ((cfg_i.reg_index == CFG_BASE) |
                                 (cfg_i.reg_index == CFG_SIZE) |
                                 (cfg_i.reg_index == CFG_COUNT));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_act == ACT_ALLOC) begin
            if (head_nz) begin
              state_d = ST_LINK;
            end else if (hw_avail) begin
              state_d = ST_MUL;
            end else begin
              state_d = ST_DONE;
            end
          end else if (in_i.is_null) begin
            state_d = ST_DONE;
          end else begin
            unique case (in_act) inside
              ACT_FREE, ACT_ADDR2IDX: state_d = (addr_low | quo_over) ? ST_DONE : ST_DIV;
              default:                state_d = bidx_ok ? ST_MUL : ST_DONE;
            endcase
          end
        end
      end
      ST_LINK:  state_d = ST_MUL;
      ST_DIV: begin
        if (cnt_q == KW'(CW - 1)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ((quo_q < hw_q) && (act_q == ACT_ADDR2IDX)) ? ST_MUL : ST_DONE;
      end
      ST_MUL:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and RAM controls
  // ---------------------------------------------------------------------------
  always_comb begin
    base_d    = base_q;
    size_d    = size_q;
    count_d   = count_q;
    head_d    = head_q;
    hw_d      = hw_q;
    act_d     = act_q;
    status_d  = status_q;
    idx_d     = idx_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    cnt_d     = cnt_q;
    prod_d    = prod_q;
    addr_d    = addr_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          act_d    = in_act;
          status_d = STAT_OK;
          idx_d    = '0;
          addr_d   = '0;
          quo_d    = '0;
          cnt_d    = '0;
          rem_d    = RW'(diff);
          dvs_d    = RW'(size_q) << (CW - 1);
          if (in_act == ACT_ALLOC) begin
            if (head_nz) begin
              // pop: fetch the successor of the head block
              mem_re   = 1'b1;
              mem_addr = IW'(head_q - 1'b1);
              idx_d    = head_q - 1'b1;
            end else if (hw_avail) begin
              idx_d = hw_q;
              hw_d  = hw_q + 1'b1;
            end else begin
              status_d = STAT_EXHAUSTED;
            end
          end else if (in_i.is_null) begin
            status_d = STAT_NULL;
          end else begin
            unique case (in_act) inside
              ACT_FREE, ACT_ADDR2IDX: begin
                if (addr_low | quo_over) begin
                  status_d = STAT_RANGE;
                end
              end
              default: begin
                if (bidx_ok) begin
                  idx_d = CW'(in_i.block_index);
                end else begin
                  status_d = STAT_RANGE;
                end
              end
            endcase
          end
        end
      end
      ST_LINK: head_d = link_rdata_q;
      ST_DIV: begin
        // restoring division, one quotient bit a cycle
        if (div_bit) begin
          rem_d = rem_q - dvs_q;
        end
        quo_d = {quo_q[CW-2:0], div_bit};
        dvs_d = dvs_q >> 1;
        cnt_d = cnt_q + 1'b1;
      end
      ST_CHECK: begin
        if (quo_q < hw_q) begin
          idx_d = quo_q;
          if (act_q == ACT_FREE) begin
            // push: old head becomes the successor
            mem_we    = 1'b1;
            mem_addr  = IW'(quo_q);
            mem_wdata = head_q;
            head_d    = quo_q + 1'b1;
          end
        end else begin
          status_d = STAT_RANGE;
        end
      end
      ST_MUL:  prod_d = RW'(idx_q) * RW'(size_q);
      ST_ADD:  addr_d = base_q + AW'(prod_q);
      ST_DONE: ;
      default: ;
    endcase

    if (cfg_fire) begin
      unique case (cfg_i.reg_index)
        CFG_BASE:  base_d = cfg_i.data[AW-1:0];
        CFG_SIZE:  size_d = (cfg_size < MIN_BLOCK_SIZE) ? MIN_BLOCK_SIZE : cfg_size;
        CFG_COUNT: count_d = (32'(cfg_count) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(cfg_count);
        default: ;
      endcase
    end
    if (cfg_hit) begin
      head_d = '0;
      hw_d   = '0;
    end
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_o.ready);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      size_q      <= MIN_BLOCK_SIZE;
      count_q     <= '0;
      head_q      <= '0;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      size_q      <= size_d;
      count_q     <= count_d;
      head_q      <= head_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    status_q <= status_d;
    idx_q    <= idx_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    cnt_q    <= cnt_d;
    prod_q   <= prod_d;
    addr_q   <= addr_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_addr_q   <= ADDR_W'(addr_q);
      out_idx_q    <= INDEX_W'(idx_q);
    end
  end

  // link RAM, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      link_rdata_q <= link_mem[mem_addr];
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.result_address = out_addr_q;
  assign out_o.result_index   = out_idx_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FBFL_ASSERT_NEXT(a_cfg_empties_pool, clk_i, rst_ni, cfg_hit, head_q == '0 && hw_q == '0, "register write did not empty the pool")
  `FBFL_ASSERT(a_hw_within_count, clk_i, rst_ni, 1'b1, hw_q <= count_q, "high-water mark beyond block count")
  `FBFL_ASSERT(a_head_below_hw, clk_i, rst_ni, 1'b1, head_q <= hw_q, "free list head beyond high-water mark")
  `FBFL_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_fire, state_q != ST_IDLE, "request beat taken without leaving idle")

endmodule
